/* rtl/key_debounce_autorepeat_assert.svh */
// Assertion macros used by the checker of the key debounce block.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kda_pkg.sv */
`default_nettype none

package kda_pkg;

  // Default geometry
  localparam int unsigned KEY_COUNT_DEF   = 16;
  localparam int unsigned FILTER_BITS_DEF = 4;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned EXP_W   = 3;

  // Repeat period exponents: period is 1 << exp
  localparam logic [EXP_W-1:0] RPT_FIRST_EXP = 3'd4;
  localparam logic [EXP_W-1:0] RPT_PAUSE_EXP = 3'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 8'd32;
  localparam logic [CFG_W-1:0] FIRST_REPEAT_RST = 8'd40;
  localparam logic [CFG_W-1:0] RATE_STEP_RST    = 8'd48;
  localparam logic [CFG_W-1:0] PAUSE_RST        = 8'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_PAUSE  = 2'd1,
    CMD_KILL   = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    EV_FIRST   = 2'd0,
    EV_LONG    = 2'd1,
    EV_REPEAT  = 2'd2,
    EV_RELEASE = 2'd3
  } ev_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_FIRST_REPEAT = 2'd1,
    CFG_RATE_STEP    = 2'd2,
    CFG_PAUSE        = 2'd3
  } cfg_idx_e;

  // Per-key phase, one-hot
  typedef enum logic [5:0] {
    PH_OFF    = 6'b000001,
    PH_START  = 6'b000010,
    PH_DELAY  = 6'b000100,
    PH_PAUSE  = 6'b001000,
    PH_KILLED = 6'b010000,
    PH_RPT    = 6'b100000
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [EXP_W-1:0]   rpt_exp;
    logic [CNT_W-1:0]   tick_count;
  } key_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] first_repeat_ticks;
    logic [CFG_W-1:0] rate_step_ticks;
    logic [CFG_W-1:0] pause_ticks;
  } cfg_t;

  localparam key_state_t KEY_STATE_RST = '{phase: PH_OFF, rpt_exp: '0, tick_count: '0};

endpackage

`default_nettype wire

/* rtl/kda_if.sv */
`default_nettype none

// Input item channel
interface kda_in_if import kda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key_index;
  logic             raw_level;

  modport source (output valid, command, key_index, raw_level, input ready);
  modport sink   (input valid, command, key_index, raw_level, output ready);
endinterface

// Result item channel
interface kda_out_if import kda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [KEY_W-1:0]  event_key;

  modport source (output valid, event_kind, event_key, input ready);
  modport sink   (input valid, event_kind, event_key, output ready);
endinterface

// Register write channel
interface kda_cfg_if import kda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/kda_ram.sv */
`default_nettype none

module kda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    raddr_i,
  output      logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/kda_cfg_regs.sv */
`default_nettype none

module kda_cfg_regs import kda_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kda_cfg_if.sink    cfg_i,
  output      cfg_t  cfg_o
);

  cfg_t cfg_q;

  // Writes are never stalled
  assign cfg_i.ready = 1'b1;

  // Update the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= LONG_PRESS_RST;
      cfg_q.first_repeat_ticks <= FIRST_REPEAT_RST;
      cfg_q.rate_step_ticks    <= RATE_STEP_RST;
      cfg_q.pause_ticks        <= PAUSE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LONG_PRESS:   cfg_q.long_press_ticks   <= cfg_i.data;
        CFG_FIRST_REPEAT: cfg_q.first_repeat_ticks <= cfg_i.data;
        CFG_RATE_STEP:    cfg_q.rate_step_ticks    <= cfg_i.data;
        CFG_PAUSE:        cfg_q.pause_ticks        <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/kda_key_update.sv */
`default_nettype none

module kda_key_update import kda_pkg::*; #(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
  input  wire logic [CMD_W-1:0]       cmd_i,
  input  wire logic                   level_i,
  input  wire logic [FILTER_BITS-1:0] hist_i,
  input  wire key_state_t             state_i,
  input  wire cfg_t                   cfg_i,
  output      logic [FILTER_BITS-1:0] hist_o,
  output      key_state_t             state_o,
  output      logic                   ev_valid_o,
  output      ev_kind_e               ev_kind_o
);

  key_state_t st;
  logic [FILTER_BITS-1:0] hist;
  logic [3:0] period_mask;

  always_comb begin
    st          = state_i;
    hist        = hist_i;
    ev_valid_o  = 1'b0;
    ev_kind_o   = EV_FIRST;
    period_mask = '0;

    case (cmd_i)
      CMD_SAMPLE: begin
        // Shift the raw level in and advance the tick counter
        hist          = FILTER_BITS'({hist_i, level_i});
        st.tick_count = state_i.tick_count + 8'd1;

        // Settled low: release, silent if killed
        if (st.phase != PH_OFF && hist == '0) begin
          if (st.phase != PH_KILLED) begin
            ev_valid_o = 1'b1;
            ev_kind_o  = EV_RELEASE;
          end
          st.tick_count = '0;
          st.phase      = PH_OFF;
        end

        case (st.phase)
          PH_OFF: begin
            if (hist == '1) begin
              st.phase      = PH_START;
              st.tick_count = '0;
            end
          end
          PH_START: begin
            ev_valid_o    = 1'b1;
            ev_kind_o     = EV_FIRST;
            st.phase      = PH_DELAY;
            st.tick_count = '0;
          end
          PH_DELAY: begin
            if (st.tick_count == cfg_i.long_press_ticks) begin
              ev_valid_o = 1'b1;
              ev_kind_o  = EV_LONG;
            end
            if (st.tick_count == cfg_i.first_repeat_ticks) begin
              st.phase      = PH_RPT;
              st.rpt_exp    = RPT_FIRST_EXP;
              st.tick_count = '0;
            end
          end
          PH_PAUSE: begin
            if (st.tick_count >= cfg_i.pause_ticks) begin
              st.phase      = PH_RPT;
              st.rpt_exp    = RPT_PAUSE_EXP;
              st.tick_count = '0;
            end
          end
          PH_RPT: begin
            // Halve the period once the current rate has run its course
            if (st.rpt_exp != '0 && st.tick_count >= cfg_i.rate_step_ticks) begin
              st.rpt_exp    = st.rpt_exp - 3'd1;
              st.tick_count = '0;
            end
            period_mask = (4'd1 << st.rpt_exp) - 4'd1;
            if ((st.tick_count[3:0] & period_mask) == 4'd0) begin
              ev_valid_o = 1'b1;
              ev_kind_o  = EV_REPEAT;
            end
          end
          default: ;
        endcase
      end
      CMD_PAUSE: begin
        st.phase      = PH_PAUSE;
        st.tick_count = '0;
      end
      CMD_KILL: begin
        st.phase = PH_KILLED;
      end
      default: ;
    endcase

    hist_o  = hist;
    state_o = st;
  end

endmodule

`default_nettype wire

/* rtl/key_debounce_autorepeat.sv */
// Channel  | Dir | Payload                           | Accepted when
// ---------+-----+-----------------------------------+------------------
// in_i     | in  | command, key_index, raw_level     | valid & ready
// out_o    | out | event_kind, event_key             | valid & ready
// cfg_i    | in  | index, data                       | valid & ready
//
// One item per cycle sustained while out_o is not stalled. An accepted item reads its
// key's state from the key state RAM, is updated in the following cycle and its
// result, if any, is written to the output register once that register is free.
// Back-to-back items on the same key are forwarded around the RAM read.
// Reset clears all keys at once through per-key valid bits; no sweep.
// in_i.ready drops only while a result waits on out_o and the update stage
// is occupied. cfg_i.ready is always high.
`default_nettype none

module key_debounce_autorepeat import kda_pkg::*; #(
  parameter int unsigned KEY_COUNT   = KEY_COUNT_DEF,
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kda_in_if.sink     in_i,
  kda_out_if.source  out_o,
  kda_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = $clog2(KEY_COUNT > 1 ? KEY_COUNT : 2);
  localparam int unsigned WW = FILTER_BITS + $bits(key_state_t);

  cfg_t cfg;

  // Update stage
  logic             st_valid_q;
  logic             st_inrange_q;
  logic [CMD_W-1:0] st_cmd_q;
  logic [KEY_W-1:0] st_key_q;
  logic [AW-1:0]    st_addr_q;
  logic             st_level_q;

  // Forwarding of a write that raced a read
  logic             fwd_valid_q;
  logic [AW-1:0]    fwd_addr_q;
  logic [WW-1:0]    fwd_data_q;

  logic [KEY_COUNT-1:0] written_q;

  // Output register
  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [KEY_W-1:0]  out_key_q;

  logic                   advance;
  logic                   in_ready;
  logic                   accept;
  logic                   ram_we;
  logic [WW-1:0]          ram_rdata;
  logic [WW-1:0]          cur_word;
  logic [WW-1:0]          new_word;
  logic [FILTER_BITS-1:0] cur_hist;
  key_state_t             cur_state;
  logic [FILTER_BITS-1:0] new_hist;
  key_state_t             new_state;
  logic                   ev_valid;
  ev_kind_e               ev_kind;

  kda_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake
  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !st_valid_q || advance;
  assign accept   = in_i.valid && in_ready;
  assign ram_we   = st_valid_q && advance && st_inrange_q;

  assign in_i.ready = in_ready;

  kda_ram #(
    .WIDTH (WW),
    .DEPTH (KEY_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (st_addr_q),
    .wdata_i (new_word),
    .re_i    (accept),
    .raddr_i (AW'(in_i.key_index)),
    .rdata_o (ram_rdata)
  );

  // Pick the freshest state for the staged key
  always_comb begin
    if (fwd_valid_q && fwd_addr_q == st_addr_q) begin
      cur_word = fwd_data_q;
    end else if (st_inrange_q && written_q[st_addr_q]) begin
      cur_word = ram_rdata;
    end else begin
      cur_word = {{FILTER_BITS{1'b0}}, KEY_STATE_RST};
    end
  end

  assign cur_hist  = cur_word[WW-1 -: FILTER_BITS];
  assign cur_state = key_state_t'(cur_word[$bits(key_state_t)-1:0]);
  assign new_word  = {new_hist, new_state};

  kda_key_update #(
    .FILTER_BITS (FILTER_BITS)
  ) u_upd (
    .cmd_i      (st_cmd_q),
    .level_i    (st_level_q),
    .hist_i     (cur_hist),
    .state_i    (cur_state),
    .cfg_i      (cfg),
    .hist_o     (new_hist),
    .state_o    (new_state),
    .ev_valid_o (ev_valid),
    .ev_kind_o  (ev_kind)
  );

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      written_q   <= '0;
    end else begin
      if (in_ready) begin
        st_valid_q <= in_i.valid;
      end
      if (accept) begin
        fwd_valid_q <= ram_we;
      end
      if (ram_we) begin
        written_q[st_addr_q] <= 1'b1;
      end
    end
  end

  // Capture the item and the racing write
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_cmd_q     <= in_i.command;
      st_key_q     <= in_i.key_index;
      st_addr_q    <= AW'(in_i.key_index);
      st_level_q   <= in_i.raw_level;
      st_inrange_q <= 32'(in_i.key_index) < KEY_COUNT;
      fwd_addr_q   <= st_addr_q;
      fwd_data_q   <= new_word;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= st_valid_q && st_inrange_q && ev_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= ev_kind;
      out_key_q  <= st_key_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = out_kind_q;
  assign out_o.event_key  = out_key_q;

endmodule

`default_nettype wire

/* rtl/kda_checker.sv */
`default_nettype none

`include "key_debounce_autorepeat_assert.svh"

module kda_checker import kda_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic [KEY_W-1:0]  in_key_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [KIND_W-1:0] out_kind_i,
  input wire logic [KEY_W-1:0]  out_key_i,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_i
);

  // A stalled result holds
  `KDA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_key_i), "stalled result changed")

  // A fresh result comes from an item taken earlier with the same key
  `KDA_ASSERT_IMP(a_out_origin, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2) && out_key_i == $past(in_key_i, 2), "result without matching item")

  // The input side stalls only behind a stalled result
  `KDA_ASSERT_IMP(a_in_ready, clk_i, rst_ni, !(out_valid_i && !out_ready_i), in_ready_i, "input stalled without backpressure")

  // Register writes are never held off
  `KDA_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_i, "register write stalled")

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_key_i    (in_i.key_index),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.event_kind),
  .out_key_i   (out_o.event_key),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire

/* test/tb_key_debounce_autorepeat.sv */
`timescale 1ns / 100ps

module tb_key_debounce_autorepeat import kda_pkg::*; ();

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TIMEOUT_NS      = 5_000_000;

  typedef struct packed {
    ev_kind_e         kind;
    logic [KEY_W-1:0] key;
  } key_event_t;

  // Track every key's debounce state and the events it must produce
  class key_event_scoreboard;
    logic [CFG_W-1:0]           long_press, first_repeat, rate_step, pause_len;
    logic [FILTER_BITS_DEF-1:0] hist    [KEY_COUNT_DEF];
    phase_e                     ph      [KEY_COUNT_DEF];
    logic [EXP_W-1:0]           rpt_exp [KEY_COUNT_DEF];
    logic [CNT_W-1:0]           ticks   [KEY_COUNT_DEF];
    key_event_t                 pending_events [$];
    int                         errors;

    function new();
      long_press   = LONG_PRESS_RST;
      first_repeat = FIRST_REPEAT_RST;
      rate_step    = RATE_STEP_RST;
      pause_len    = PAUSE_RST;
      errors       = 0;
      for (int i = 0; i < KEY_COUNT_DEF; i++) begin
        hist[i]    = '0;
        ph[i]      = PH_OFF;
        rpt_exp[i] = '0;
        ticks[i]   = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (cfg_idx_e'(idx))
        CFG_LONG_PRESS:   long_press   = val;
        CFG_FIRST_REPEAT: first_repeat = val;
        CFG_RATE_STEP:    rate_step    = val;
        CFG_PAUSE:        pause_len    = val;
        default: ;
      endcase
    endfunction

    // Advance one key on an accepted item and queue the event it causes
    function void apply_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, logic lvl);
      logic [FILTER_BITS_DEF-1:0] h;
      phase_e                     st;
      logic [EXP_W-1:0]           e;
      logic [CNT_W-1:0]           cnt;
      bit                         fire;
      ev_kind_e                   kind;
      case (cmd)
        CMD_SAMPLE: begin
          h    = {hist[key][FILTER_BITS_DEF-2:0], lvl};
          st   = ph[key];
          e    = rpt_exp[key];
          cnt  = ticks[key] + 8'd1;
          fire = 1'b0;
          kind = EV_FIRST;
          // Drop back to off on a clean release; a killed key stays silent
          if (st != PH_OFF && h == '0) begin
            if (st != PH_KILLED) begin
              fire = 1'b1;
              kind = EV_RELEASE;
            end
            cnt = '0;
            st  = PH_OFF;
          end
          case (st)
            PH_OFF: begin
              if (h == '1) begin
                st  = PH_START;
                cnt = '0;
              end
            end
            PH_START: begin
              fire = 1'b1;
              kind = EV_FIRST;
              st   = PH_DELAY;
              cnt  = '0;
            end
            PH_DELAY: begin
              if (cnt == long_press) begin
                fire = 1'b1;
                kind = EV_LONG;
              end
              if (cnt == first_repeat) begin
                st  = PH_RPT;
                e   = RPT_FIRST_EXP;
                cnt = '0;
              end
            end
            PH_PAUSE: begin
              if (cnt >= pause_len) begin
                st  = PH_RPT;
                e   = RPT_PAUSE_EXP;
                cnt = '0;
              end
            end
            PH_RPT: begin
              // Halve the period once the current rate has run its course
              if (e != '0 && cnt >= rate_step) begin
                e   = e - 1'b1;
                cnt = '0;
              end
              if ((cnt & ((8'd1 << e) - 8'd1)) == '0) begin
                fire = 1'b1;
                kind = EV_REPEAT;
              end
            end
            default: ;
          endcase
          hist[key]    = h;
          ph[key]      = st;
          rpt_exp[key] = e;
          ticks[key]   = cnt;
          if (fire) pending_events.push_back('{kind: kind, key: key});
        end
        CMD_PAUSE: begin
          ph[key]    = PH_PAUSE;
          ticks[key] = '0;
        end
        CMD_KILL: ph[key] = PH_KILLED;
        default: ;
      endcase
    endfunction

    // Compare one delivered event with the oldest one owed
    function void check_event(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
      key_event_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual kind %0d key %0d",
                 $time, kind, key);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (want.kind != kind) begin
        $display("%0t: event kind mismatch: expected %0d, actual %0d", $time, want.kind, kind);
        errors++;
      end
      if (want.key != key) begin
        $display("%0t: event key mismatch: expected %0d, actual %0d", $time, want.key, key);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic hold_req;
  logic calm;
  logic rx_busy;
  logic             tgt_level [KEY_COUNT_DEF];
  int unsigned      remain    [KEY_COUNT_DEF];

  kda_in_if  in_if ();
  kda_out_if out_if ();
  kda_cfg_if cfg_if ();

  key_event_scoreboard board = new();

  key_debounce_autorepeat uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watch all three channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        board.check_event(out_if.event_kind, out_if.event_key);
      end
      if (in_if.valid && in_if.ready) begin
        board.apply_item(in_if.command, in_if.key_index, in_if.raw_level);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        board.write_reg(cfg_if.index, cfg_if.data);
      end
    end
  end

  // Result side: random stalls, one long hold-off on request, none when calm
  initial begin
    out_if.ready = 1'b0;
    rx_busy      = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_if.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (!calm && rx_busy && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
      if ($urandom_range(0, 149) == 0) rx_busy = !rx_busy;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic lvl);
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.command   = cmd;
    in_if.key_index = key;
    in_if.raw_level = lvl;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic idle_in(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] fr,
                            input logic [CFG_W-1:0] rs, input logic [CFG_W-1:0] ps);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_FIRST_REPEAT, fr);
    write_reg(CFG_RATE_STEP, rs);
    write_reg(CFG_PAUSE, ps);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Hold the input until every owed event is out, then let the pipe empty
  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (board.pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_threshold();
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom_range(1, 255));
    return CFG_W'($urandom_range(1, 24));
  endfunction

  // Press and release a few keys with realistic hold times, plus some noise
  task automatic run_phase(input int n_items, input int pool_n, input int noise_pct,
                           input int long_pct, input bit gaps, input int hold_at);
    logic [KEY_W-1:0] pool [4];
    logic [KEY_W-1:0] k;
    logic [CMD_W-1:0] cmd;
    logic             lvl;
    for (int i = 0; i < 4; i++) pool[i] = KEY_W'($urandom_range(0, 15));
    for (int n = 0; n < n_items; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      if (gaps && !calm && $urandom_range(0, 7) == 0) idle_in($urandom_range(1, 18));
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_PAUSE;
          1:       cmd = CMD_KILL;
          default: cmd = CMD_UNUSED;
        endcase
        send_item(cmd, KEY_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else begin
        k = pool[$urandom_range(0, pool_n - 1)];
        if (remain[k] == 0) begin
          tgt_level[k] = !tgt_level[k];
          if (!tgt_level[k]) remain[k] = $urandom_range(4, 10);
          else if ($urandom_range(0, 99) < long_pct) remain[k] = $urandom_range(260, 330);
          else remain[k] = $urandom_range(5, 60);
        end
        remain[k]--;
        lvl = tgt_level[k];
        // Bounce the contact now and then
        if (noise_pct != 0 && $urandom_range(0, 19) == 0) lvl = !lvl;
        send_item(CMD_SAMPLE, k, lvl);
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    calm            = 1'b0;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_SAMPLE;
    in_if.key_index = '0;
    in_if.raw_level = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_LONG_PRESS;
    cfg_if.data     = '0;
    for (int i = 0; i < KEY_COUNT_DEF; i++) begin
      tgt_level[i] = 1'b0;
      remain[i]    = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: long press and repeat entry on the same tick, pause, kill
    write_regs(8'd3, 8'd3, 8'd2, 8'd2);
    send_item(CMD_UNUSED, 4'd5, 1'b1);
    repeat (4) send_item(CMD_SAMPLE, 4'd15, 1'b1);
    repeat (4) send_item(CMD_SAMPLE, 4'd15, 1'b1);
    send_item(CMD_PAUSE, 4'd15, 1'b0);
    repeat (4) send_item(CMD_SAMPLE, 4'd15, 1'b1);
    send_item(CMD_KILL, 4'd15, 1'b1);
    repeat (4) send_item(CMD_SAMPLE, 4'd15, 1'b0);
    // Pause or kill an idle key, then sample it low
    send_item(CMD_PAUSE, 4'd0, 1'b1);
    send_item(CMD_SAMPLE, 4'd0, 1'b0);
    send_item(CMD_KILL, 4'd1, 1'b0);
    send_item(CMD_SAMPLE, 4'd1, 1'b0);
    send_item(CMD_SAMPLE, 4'd7, 1'b1);
    send_item(CMD_SAMPLE, 4'd7, 1'b0);

    // Fastest settings: one event per pressed sample, with a long hold-off
    drain_results();
    write_regs(8'd1, 8'd1, 8'd1, 8'd1);
    run_phase(150, 1, 0, 100, 1'b1, 30);

    // Slowest settings on one long-held key
    drain_results();
    write_regs(8'd255, 8'd255, 8'd255, 8'd255);
    run_phase(400, 1, 0, 100, 1'b0, -1);

    drain_results();
    write_regs(LONG_PRESS_RST, FIRST_REPEAT_RST, RATE_STEP_RST, PAUSE_RST);
    run_phase(150, 2, 5, 30, 1'b1, -1);

    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_regs(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold());
      run_phase(120, $urandom_range(1, 4), 8, 15, 1'($urandom_range(0, 1)), -1);
    end

    // Closing stretch at full rate on both sides
    drain_results();
    calm = 1'b1;
    write_regs(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold());
    run_phase(100, 3, 8, 10, 1'b0, -1);

    drain_results();
    if (board.errors == 0 && board.pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
